@@ sv/mfpd_pkg.sv @@
// shared types and constants of the matched filter peak detector
`default_nettype none
package mfpd_pkg;

   localparam int WinDepth  = 256;
   localparam int AddrW     = 8;
   localparam int MaxTaps   = 32;
   localparam int SampleW   = 8;
   localparam int SumW      = 16;
   localparam int DivNumW   = 28;
   localparam int DivDenW   = 16;
   localparam int DivSteps  = 28;
   localparam int DivCntW   = 5;
   localparam int CsrAddrW  = 3;
   localparam int CsrDataW  = 64;
   localparam int RspDataW  = 64;

   localparam logic [11:0] NormScale = 12'd4095;
   localparam logic [6:0]  NormFull  = 7'd127;
   localparam logic [9:0]  CountMax  = 10'd1023;

   localparam logic [CsrAddrW-1:0] CSR_COEF0  = 3'd0;
   localparam logic [CsrAddrW-1:0] CSR_COEF1  = 3'd1;
   localparam logic [CsrAddrW-1:0] CSR_COEF2  = 3'd2;
   localparam logic [CsrAddrW-1:0] CSR_COEF3  = 3'd3;
   localparam logic [CsrAddrW-1:0] CSR_TAPS   = 3'd4;
   localparam logic [CsrAddrW-1:0] CSR_REPEAT = 3'd5;
   localparam logic [CsrAddrW-1:0] CSR_WEIGHT = 3'd6;
   localparam logic [CsrAddrW-1:0] CSR_POINTS = 3'd7;

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] dividend;
      logic [DivDenW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DivNumW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_MAC    = 9'b000000100,
      ST_DRAIN  = 9'b000001000,
      ST_UPDATE = 9'b000010000,
      ST_NORM_P = 9'b000100000,
      ST_NORM_T = 9'b001000000,
      ST_RATIO  = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

@@ sv/mfpd_div.sv @@
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module mfpd_div
   import mfpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req_in,
   output div_rsp_type      rsp_out
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivCntW-1:0] cnt_ff;
   logic [DivDenW-1:0] rem_ff;
   logic [DivNumW-1:0] quo_ff;
   logic [DivDenW-1:0] den_ff;
   logic [DivDenW:0]   trial;
   logic [DivDenW:0]   diff;
   logic               ge;

   assign trial = {rem_ff, quo_ff[DivNumW-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req_in.start && !busy_ff) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == DivCntW'(DivSteps - 1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_in.start && !busy_ff) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         quo_ff <= req_in.dividend;
         den_ff <= req_in.divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
         quo_ff <= {quo_ff[DivNumW-2:0], ge};
      end
   end

   assign rsp_out.busy     = busy_ff;
   assign rsp_out.done     = done_ff;
   assign rsp_out.quotient = quo_ff;

endmodule
`default_nettype wire

@@ sv/matched_filter_peak_detector_top.sv @@
// matched filter peak detector: window memory, shared mac loop, shared divider
// per sample: idle, then the mac loop over len window taps, one tap per cycle, drain and
//   update (len = tap_count * repeat_factor mod 256; a sample with no taps skips to update)
// a frame-closing sample adds up to three divider passes and an emit step, which waits
//   for a free output register; one sample at a time, ready only when idle
// synchronous reset, then a clear of all 256 window entries with req_tready low
`default_nettype none
module matched_filter_peak_detector_top
   import mfpd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input samples
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] sample
   // frame results
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspDataW-1:0]      rsp_tdata,   // [15:0] magnitude, [31:16] quality_ratio,
                                                 // [32] ratio_invalid, [47:33] raw_peak,
                                                 // [63:48] raw_trough
   // configuration writes
   input  wire logic                csr_we,
   input  wire logic [CsrAddrW-1:0] csr_addr,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   // configuration registers
   logic [3:0][63:0] coef_ff;
   logic [31:0][7:0] coef_bytes;
   logic [5:0]       taps_ff;
   logic [3:0]       rep_ff;
   logic [7:0]       wsum_ff;
   logic [7:0]       pts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         taps_ff <= 6'd1;
         rep_ff  <= 4'd1;
         wsum_ff <= 8'd1;
         pts_ff  <= 8'd1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_COEF0:  coef_ff[0] <= csr_wdata;
            CSR_COEF1:  coef_ff[1] <= csr_wdata;
            CSR_COEF2:  coef_ff[2] <= csr_wdata;
            CSR_COEF3:  coef_ff[3] <= csr_wdata;
            CSR_TAPS:   taps_ff    <= csr_wdata[5:0];
            CSR_REPEAT: rep_ff     <= csr_wdata[3:0];
            CSR_WEIGHT: wsum_ff    <= csr_wdata[7:0];
            CSR_POINTS: pts_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign coef_bytes = coef_ff;

   // sequencer state
   state_type          state_ff, state_in;
   logic [AddrW-1:0]   clr_ff, clr_in;
   logic [AddrW-1:0]   wp_ff, wp_in;
   logic [9:0]         cnt_ff, cnt_in;
   logic signed [15:0] peak_ff, peak_in;
   logic signed [15:0] trough_ff, trough_in;
   logic               phase_ff, phase_in;
   logic               p1_ff, p1_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-sample working registers
   logic [7:0]         len_ff, len_in;
   logic [9:0]         target_ff, target_in;
   logic               active_ff, active_in;
   logic [AddrW-1:0]   base_ff, base_in;
   logic [7:0]         i_ff, i_in;
   logic [7:0]         idx_ff, idx_in;
   logic [3:0]         rcnt_ff, rcnt_in;
   logic signed [15:0] acc_ff, acc_in;
   logic signed [7:0]  coef_p1_ff;
   logic signed [7:0]  rd_data_ff;
   logic signed [15:0] pn_ff, pn_in;
   logic signed [15:0] tn_ff, tn_in;
   logic signed [15:0] mag_ff, mag_in;
   logic [15:0]        qr_ff, qr_in;
   logic               bad_ff, bad_in;
   logic [RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // helpers
   logic               req_fire;
   logic [9:0]         len_prod;
   logic [7:0]         len_c;
   logic [7:0]         need_c;
   logic [7:0]         pc_c;
   logic [9:0]         cnt_next_c;
   logic [AddrW-1:0]   rd_addr;
   logic signed [7:0]  coef_c;
   logic signed [15:0] prod;
   logic signed [15:0] norm_v;
   logic [15:0]        abs_v;
   logic [15:0]        norm_den;
   logic [DivNumW-1:0] q;
   logic signed [15:0] norm_q;
   logic signed [15:0] norm_zero;
   logic signed [16:0] pn17;
   logic signed [16:0] ntn17;
   logic               dom_pos;
   logic signed [16:0] num17;
   logic signed [16:0] den17;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // window memory
   logic signed [7:0]  win_mem [WinDepth];
   logic               mem_we;
   logic [AddrW-1:0]   mem_wa;
   logic signed [7:0]  mem_wd;

   assign req_fire = req_tvalid && req_tready;
   assign mem_we   = (state_ff == ST_CLEAR) || req_fire;
   assign mem_wa   = (state_ff == ST_CLEAR) ? clr_ff : wp_ff;
   assign mem_wd   = (state_ff == ST_CLEAR) ? 8'sd0 : $signed(req_tdata);
   assign rd_addr  = base_ff + i_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= win_mem[rd_addr];
   end

   // frame geometry from the current registers
   assign len_prod   = 10'(taps_ff * rep_ff);
   assign len_c      = len_prod[7:0];
   assign need_c     = (len_c == 8'd0) ? 8'd1 : len_c;
   assign pc_c       = (pts_ff == 8'd0) ? 8'd1 : pts_ff;
   assign cnt_next_c = (cnt_ff == CountMax) ? cnt_ff : cnt_ff + 10'd1;

   // coefficient lookup, zero beyond the bank
   assign coef_c = (idx_ff < 8'(MaxTaps)) ? $signed(coef_bytes[idx_ff[4:0]]) : 8'sd0;
   assign prod   = 16'(coef_p1_ff * rd_data_ff);

   // normalization operands
   assign norm_v    = (state_ff == ST_NORM_P) ? peak_ff : trough_ff;
   assign abs_v     = norm_v[15] ? (~norm_v + 16'd1) : norm_v;
   assign norm_den  = 16'(wsum_ff * NormFull);
   assign q         = div_rsp.quotient;
   assign norm_zero = (norm_v > 16'sd0) ? 16'sd32767 :
                      (norm_v < 16'sd0) ? -16'sd32768 : 16'sd0;
   always_comb begin
      if (!norm_v[15]) begin
         norm_q = (q > DivNumW'(32767)) ? 16'sd32767 : $signed(q[15:0]);
      end else begin
         norm_q = (q > DivNumW'(32768)) ? -16'sd32768 : $signed(16'd0 - q[15:0]);
      end
   end

   // dominant extreme selection
   assign pn17    = {pn_ff[15], pn_ff};
   assign ntn17   = -$signed({tn_ff[15], tn_ff});
   assign dom_pos = pn17 > ntn17;
   assign num17   = dom_pos ? pn17 : ntn17;
   assign den17   = dom_pos ? ntn17 : pn17;

   always_comb begin
      div_req = '0;
      if ((state_ff == ST_NORM_P || state_ff == ST_NORM_T) && !phase_ff
          && wsum_ff != 8'd0) begin
         div_req.start    = 1'b1;
         div_req.dividend = DivNumW'(abs_v * NormScale);
         div_req.divisor  = norm_den;
      end else if (state_ff == ST_RATIO && !phase_ff && den17 > 17'sd0) begin
         div_req.start    = 1'b1;
         div_req.dividend = {3'b000, num17, 8'h00};
         div_req.divisor  = den17[15:0];
      end
   end

   mfpd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .req_in  (div_req),
      .rsp_out (div_rsp)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      peak_in      = peak_ff;
      trough_in    = trough_ff;
      phase_in     = phase_ff;
      p1_in        = (state_ff == ST_MAC);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      len_in       = len_ff;
      target_in    = target_ff;
      active_in    = active_ff;
      base_in      = base_ff;
      i_in         = i_ff;
      idx_in       = idx_ff;
      rcnt_in      = rcnt_ff;
      acc_in       = p1_ff ? acc_ff + prod : acc_ff;
      pn_in        = pn_ff;
      tn_in        = tn_ff;
      mag_in       = mag_ff;
      qr_in        = qr_ff;
      bad_in       = bad_ff;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AddrW'(WinDepth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               wp_in     = wp_ff + 1'b1;
               cnt_in    = cnt_next_c;
               len_in    = len_c;
               target_in = 10'(need_c) + 10'(pc_c) - 10'd1;
               active_in = cnt_next_c >= 10'(need_c);
               base_in   = wp_ff + 1'b1 - len_c;
               i_in      = '0;
               idx_in    = '0;
               rcnt_in   = '0;
               acc_in    = '0;
               state_in  = (cnt_next_c >= 10'(need_c) && len_c != 8'd0) ?
                           ST_MAC : ST_UPDATE;
            end
         end
         ST_MAC: begin
            i_in = i_ff + 8'd1;
            if (rcnt_ff == rep_ff - 4'd1) begin
               rcnt_in = '0;
               idx_in  = idx_ff + 8'd1;
            end else begin
               rcnt_in = rcnt_ff + 4'd1;
            end
            if (i_ff == len_ff - 8'd1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (active_ff) begin
               if (acc_ff > peak_ff) peak_in = acc_ff;
               if (acc_ff < trough_ff) trough_in = acc_ff;
            end
            bad_in   = 1'b0;
            phase_in = 1'b0;
            state_in = (cnt_ff >= target_ff) ? ST_NORM_P : ST_IDLE;
         end
         ST_NORM_P, ST_NORM_T: begin
            if (wsum_ff == 8'd0) begin
               bad_in = 1'b1;
               if (state_ff == ST_NORM_P) pn_in = norm_zero;
               else tn_in = norm_zero;
               state_in = (state_ff == ST_NORM_P) ? ST_NORM_T : ST_RATIO;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               if (state_ff == ST_NORM_P) pn_in = norm_q;
               else tn_in = norm_q;
               state_in = (state_ff == ST_NORM_P) ? ST_NORM_T : ST_RATIO;
            end
         end
         ST_RATIO: begin
            mag_in = dom_pos ? pn_ff : tn_ff;
            if (den17 <= 17'sd0) begin
               bad_in   = 1'b1;
               qr_in    = 16'hFFFF;
               state_in = ST_EMIT;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (div_rsp.done) begin
               phase_in = 1'b0;
               qr_in    = (q > DivNumW'(65535)) ? 16'hFFFF : q[15:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold the frame until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {trough_ff, peak_ff[14:0], bad_ff, qr_ff, mag_ff};
               rsp_valid_in = 1'b1;
               cnt_in       = '0;
               peak_in      = '0;
               trough_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         peak_ff      <= '0;
         trough_ff    <= '0;
         phase_ff     <= 1'b0;
         p1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         peak_ff      <= peak_in;
         trough_ff    <= trough_in;
         phase_ff     <= phase_in;
         p1_ff        <= p1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      target_ff   <= target_in;
      active_ff   <= active_in;
      base_ff     <= base_in;
      i_ff        <= i_in;
      idx_ff      <= idx_in;
      rcnt_ff     <= rcnt_in;
      acc_ff      <= acc_in;
      coef_p1_ff  <= coef_c;
      pn_ff       <= pn_in;
      tn_ff       <= tn_in;
      mag_ff      <= mag_in;
      qr_ff       <= qr_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // the block is busy in the cycle after it takes a sample
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("sample taken while still working on the previous one");

   // the tracked extremes never cross zero
   a_extreme_signs: assert property (@(posedge clock) disable iff (reset)
      !peak_ff[15] && (trough_ff[15] || trough_ff == 16'sd0))
      else $error("running peak or trough has the wrong sign");

   // the tap walk stays inside the filter length
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> i_ff < len_ff)
      else $error("tap index beyond filter length");

   // divider results arrive only while the sequencer waits for them
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_NORM_P || state_ff == ST_NORM_T
                        || state_ff == ST_RATIO))
      else $error("divider finished outside a division step");
`endif

endmodule
`default_nettype wire

@@ tb/sv/tb_matched_filter_peak_detector_top.sv @@
// self-checking testbench of the matched filter peak detector
`default_nettype none
module tb_matched_filter_peak_detector_top
   import mfpd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // one frame result, laid out as on rsp_tdata (lowest field last)
   typedef struct packed {
      logic [15:0] raw_trough;
      logic [14:0] raw_peak;
      logic        ratio_invalid;
      logic [15:0] quality_ratio;
      logic [15:0] magnitude;
   } frame_result_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   // directed row: a register write or a sample, optionally with a typed-in result
   typedef struct {
      row_kind_type         kind;
      logic [CsrAddrW-1:0]  addr;
      logic [CsrDataW-1:0]  data;
      logic [7:0]           sample;
      bit                   typed;
      frame_result_type     result;
   } directed_row_type;

   // result of a frame that saw only zero sums: invalid ratio, ratio field all ones, all else zero
   localparam frame_result_type ZeroFrame = 64'h0000_0001_FFFF_0000;
   localparam int DrainCycles = 400;   // covers the longest sample with margin

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CsrAddrW-1:0] csr_addr = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   matched_filter_peak_detector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // correlator model: own copy of registers and state
   // ---------------------------------------------------------------
   logic [63:0] coef_bank [4];
   int unsigned tap_count, repeat_factor, weight_sum, point_count;
   byte         window_mem [WinDepth];
   int unsigned write_ptr, frame_count;
   int          peak_sum, trough_sum;

   frame_result_type pending_frames [$];   // results still owed by the block
   int          fail_count = 0;

   // traffic shaping, changed by the stimulus process between phases
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          recv_holdoff = 0;       // long receiver stall, counted down below

   function automatic int coef_value(int unsigned idx);
      logic [7:0] b;
      if (idx >= MaxTaps) return 0;
      b = coef_bank[idx >> 3][(idx & 7) * 8 +: 8];
      return int'($signed(b));
   endfunction

   // v * 4095 / (weight * 127), truncated and saturated to 16 bits
   function automatic int scale_extreme(int v, ref bit bad);
      int d, q;
      d = weight_sum * 127;
      if (d == 0) begin
         bad = 1'b1;
         return v > 0 ? 32767 : (v < 0 ? -32768 : 0);
      end
      q = (v * 4095) / d;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   function automatic int unsigned q88_ratio(int num, int den, ref bit bad);
      longint r;
      if (den <= 0) begin
         bad = 1'b1;
         return 65535;
      end
      r = (longint'(num) * 256) / den;
      if (r > 65535) r = 65535;
      if (r < 0) r = 0;
      return int'(r);
   endfunction

   // advance the model by one sample; returns 1 when a frame closes
   function automatic bit correlate_sample(logic [7:0] s, output frame_result_type res);
      int unsigned len, need, pc, target, back, pos;
      logic [15:0] acc;
      int sum, pn, tn, mag, prod;
      int unsigned qr;
      bit bad;
      bad = 1'b0;
      res = '0;
      window_mem[write_ptr] = byte'(s);
      write_ptr = (write_ptr + 1) % WinDepth;
      if (frame_count < 1023) frame_count++;
      len = (tap_count * repeat_factor) & 8'hFF;
      need = len != 0 ? len : 1;
      pc = point_count != 0 ? point_count : 1;
      target = need + pc - 1;
      if (frame_count >= need) begin
         acc = '0;
         for (int unsigned i = 0; i < len; i++) begin
            back = len - 1 - i;
            pos = (write_ptr + 2 * WinDepth - 1 - back) % WinDepth;
            prod = coef_value(i / repeat_factor) * int'(window_mem[pos]);
            acc = acc + prod[15:0];
         end
         sum = int'($signed(acc));
         if (sum > peak_sum) peak_sum = sum;
         if (sum < trough_sum) trough_sum = sum;
      end
      if (frame_count < target) return 1'b0;
      pn = scale_extreme(peak_sum, bad);
      tn = scale_extreme(trough_sum, bad);
      if (pn > -tn) begin
         mag = pn;
         qr = q88_ratio(pn, -tn, bad);
      end else begin
         mag = tn;
         qr = q88_ratio(-tn, pn, bad);
      end
      res.magnitude     = mag[15:0];
      res.quality_ratio = qr[15:0];
      res.ratio_invalid = bad;
      res.raw_peak      = peak_sum[14:0];
      res.raw_trough    = trough_sum[15:0];
      frame_count = 0;
      peak_sum = 0;
      trough_sum = 0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // result side: stall pattern and checking
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (recv_holdoff > 0) begin
         recv_holdoff <= recv_holdoff - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      frame_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, got);
            fail_count++;
         end else begin
            want = pending_frames.pop_front();
            if (got.magnitude !== want.magnitude) begin
               $display("%0t: magnitude expected %h actual %h", $time,
                        want.magnitude, got.magnitude);
               fail_count++;
            end
            if (got.quality_ratio !== want.quality_ratio) begin
               $display("%0t: quality_ratio expected %h actual %h", $time,
                        want.quality_ratio, got.quality_ratio);
               fail_count++;
            end
            if (got.ratio_invalid !== want.ratio_invalid) begin
               $display("%0t: ratio_invalid expected %b actual %b", $time,
                        want.ratio_invalid, got.ratio_invalid);
               fail_count++;
            end
            if (got.raw_peak !== want.raw_peak) begin
               $display("%0t: raw_peak expected %h actual %h", $time,
                        want.raw_peak, got.raw_peak);
               fail_count++;
            end
            if (got.raw_trough !== want.raw_trough) begin
               $display("%0t: raw_trough expected %h actual %h", $time,
                        want.raw_trough, got.raw_trough);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // sample side
   // ---------------------------------------------------------------
   // called at a falling edge; returns at the falling edge after the beat
   task automatic push_sample(logic [7:0] s, bit typed, frame_result_type typed_res);
      frame_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      if (correlate_sample(s, res)) pending_frames.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   // sender pause: all results back, then let a sample with no result finish
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // register write at the next rising edge; caller lowers csr_we afterwards
   task automatic write_csr(logic [CsrAddrW-1:0] addr, logic [CsrDataW-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_COEF0, CSR_COEF1, CSR_COEF2, CSR_COEF3: coef_bank[addr] = data;
         CSR_TAPS:   tap_count     = data[5:0];
         CSR_REPEAT: repeat_factor = data[3:0];
         CSR_WEIGHT: weight_sum    = data[7:0];
         CSR_POINTS: point_count   = data[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [7:0] random_sample();
      case ($urandom_range(7))
         0: return 8'h80;
         1: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      directed_row_type dir_rows [$];
      int taps, reps, pts;
      for (int i = 0; i < 4; i++) coef_bank[i] = '0;
      tap_count = 1; repeat_factor = 1; weight_sum = 1; point_count = 1;
      foreach (window_mem[i]) window_mem[i] = 0;
      write_ptr = 0; frame_count = 0; peak_sum = 0; trough_sum = 0;

      // reset defaults: zero coefficients, so every sample closes a zero frame
      dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, 8'h80, 1, ZeroFrame});
      dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, 8'h7F, 1, ZeroFrame});
      dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, 8'h00, 1, ZeroFrame});
      // extreme coefficients, four taps repeated twice, full weight
      dir_rows.push_back('{ROW_CSR, CSR_COEF0, 64'h0102_7F80_FF01_807F, 8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_TAPS,   64'd4,   8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_REPEAT, 64'd2,   8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_WEIGHT, 64'd255, 8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_POINTS, 64'd3,   8'h0, 0, '0});
      for (int i = 0; i < 10; i++)
         dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, (i % 2) ? 8'h80 : 8'h7F, 0, '0});
      // zero weight: saturated normalization
      dir_rows.push_back('{ROW_CSR, CSR_WEIGHT, 64'd0, 8'h0, 0, '0});
      for (int i = 0; i < 10; i++)
         dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, (i % 2) ? 8'h7F : 8'h80, 0, '0});
      // taps past the coefficient banks, zero point count
      dir_rows.push_back('{ROW_CSR, CSR_COEF3, 64'h7F80_7F80_7F80_7F80, 8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_TAPS,   64'd40, 8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_REPEAT, 64'd1,  8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_WEIGHT, 64'd1,  8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_POINTS, 64'd0,  8'h0, 0, '0});
      for (int i = 0; i < 40; i++)
         dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, 8'h7F - 8'(i), 0, '0});
      // filter length wraps to zero: every sample is a zero-sum position
      dir_rows.push_back('{ROW_CSR, CSR_TAPS,   64'd32, 8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_REPEAT, 64'd8,  8'h0, 0, '0});
      dir_rows.push_back('{ROW_CSR, CSR_POINTS, 64'd2,  8'h0, 0, '0});
      for (int i = 0; i < 4; i++)
         dir_rows.push_back('{ROW_SAMPLE, CSR_COEF0, '0, 8'h55, 0, '0});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows: writes are grouped, the block drained before each group
      for (int r = 0; r < dir_rows.size(); r++) begin
         if (dir_rows[r].kind == ROW_CSR) begin
            if (r == 0 || dir_rows[r-1].kind != ROW_CSR) drain_results();
            write_csr(dir_rows[r].addr, dir_rows[r].data);
            if (r + 1 == dir_rows.size() || dir_rows[r+1].kind != ROW_CSR)
               csr_we <= 1'b0;
         end else begin
            if (r > 0 && dir_rows[r-1].kind == ROW_CSR) @(negedge clock);
            push_sample(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].result);
         end
      end

      // random phases, each with a fresh configuration and traffic pattern
      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         taps = $urandom_range(1, 6);
         reps = $urandom_range(1, 4);
         pts  = $urandom_range(1, 6);
         case (ph)
            2: begin taps = 63; reps = 15; pts = 255; end   // top register values
            3: pts = 1;                                      // one result per filter length of samples
            5: begin taps = 31; reps = 8; pts = 2; end       // long filter
            6: begin taps = 0; reps = 0; pts = 0; end        // bottom register values
            default: ;
         endcase
         for (int b = 0; b < 4; b++) write_csr(CsrAddrW'(b), {$urandom, $urandom});
         write_csr(CSR_TAPS, CsrDataW'(taps));
         write_csr(CSR_REPEAT, CsrDataW'(reps));
         write_csr(CSR_WEIGHT, CsrDataW'(ph == 2 ? 255 : (ph == 4 ? 0 : $urandom_range(255))));
         write_csr(CSR_POINTS, CsrDataW'(pts));
         csr_we <= 1'b0;
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         // result path blocked while samples keep coming, so input backs up
         if (ph == 3) recv_holdoff = 3000;
         @(negedge clock);
         for (int i = 0; i < 100; i++) push_sample(random_sample(), 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending_frames.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #60_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire

@@ matched_filter_peak_detector_top.f @@
sv/mfpd_pkg.sv
sv/mfpd_div.sv
sv/matched_filter_peak_detector_top.sv
tb/sv/tb_matched_filter_peak_detector_top.sv
